// ----- rtl/core/fhs_pkg.sv -----
// Shared types, constants and helper functions of the fire heat spread block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fhs_pkg;

  // Field widths of the request and response
  localparam int CellW   = 18;
  localparam int HeatW   = 6;
  localparam int ColourW = 24;

  // Hottest heat value and the matching palette entry
  localparam logic [HeatW-1:0] HEAT_MAX = 6'd35;

  // Operation codes
  localparam logic [1:0] OP_SPREAD = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Random choice code that folds onto two
  localparam logic [1:0] CHOICE_TWO   = 2'd2;
  localparam logic [1:0] CHOICE_THREE = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [CellW-1:0] cell_index;
    logic [1:0]       rand_choice;
    logic [HeatW-1:0] heat_in;
  } fhs_req_t;

  typedef struct packed {
    logic [CellW-1:0]   target_index;
    logic [HeatW-1:0]   heat_out;
    logic [ColourW-1:0] colour;
    logic               rejected;
  } fhs_rsp_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } fhs_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr_en;   // write zero at the sweep address and advance it
    logic capture;  // latch the request
    logic rd_en;    // read the source cell
    logic exec;     // compute, write back and present the result
  } fhs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last; // sweep address is at the last cell
  } fhs_stat_t;

  // Clamp a heat value to the hottest level
  function automatic logic [HeatW-1:0] sat_heat(input logic [HeatW-1:0] heat);
    sat_heat = (heat > HEAT_MAX) ? HEAT_MAX : heat;
  endfunction

  // Fire palette, 0xRRGGBB; anything above the top entry maps to white
  function automatic logic [ColourW-1:0] palette(input logic [HeatW-1:0] heat);
    logic [ColourW-1:0] c;
    case (heat)
      6'd0:    c = 24'h070707;
      6'd1:    c = 24'h1F0707;
      6'd2:    c = 24'h2F0F07;
      6'd3:    c = 24'h470F07;
      6'd4:    c = 24'h571707;
      6'd5:    c = 24'h671F07;
      6'd6:    c = 24'h771F07;
      6'd7:    c = 24'h8F2707;
      6'd8:    c = 24'h9F2F07;
      6'd9:    c = 24'hAF3F07;
      6'd10:   c = 24'hBF4707;
      6'd11:   c = 24'hC74707;
      6'd12:   c = 24'hDF4F07;
      6'd13:   c = 24'hDF5707;
      6'd14:   c = 24'hDF5707;
      6'd15:   c = 24'hD75F07;
      6'd16:   c = 24'hD7670F;
      6'd17:   c = 24'hCF6F0F;
      6'd18:   c = 24'hCF770F;
      6'd19:   c = 24'hCF7F0F;
      6'd20:   c = 24'hCF8717;
      6'd21:   c = 24'hC78717;
      6'd22:   c = 24'hC78F17;
      6'd23:   c = 24'hC7971F;
      6'd24:   c = 24'hBF9F1F;
      6'd25:   c = 24'hBF9F1F;
      6'd26:   c = 24'hBFA727;
      6'd27:   c = 24'hBFA727;
      6'd28:   c = 24'hBFAF2F;
      6'd29:   c = 24'hB7AF2F;
      6'd30:   c = 24'hB7B72F;
      6'd31:   c = 24'hB7B737;
      6'd32:   c = 24'hCFCF6F;
      6'd33:   c = 24'hDFDF9F;
      6'd34:   c = 24'hEFEFC7;
      default: c = 24'hFFFFFF;
    endcase
    palette = c;
  endfunction

endpackage

// ----- rtl/core/fhs_ctrl.sv -----
// Controller of the fire heat spread block: clear sweep, accept, read, execute.
// Depends on fhs_pkg for the state enum and the command and status structs.
`timescale 1ns / 1ps

module fhs_ctrl
  import fhs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  fhs_stat_t stat_i,
  output fhs_cmd_t  cmd_o
);

  fhs_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/core/fhs_dp.sv -----
// Datapath of the fire heat spread block: request register, heat store,
// spread arithmetic, palette lookup and result register. Depends on fhs_pkg.
`timescale 1ns / 1ps

module fhs_dp
  import fhs_pkg::*;
#(
  parameter int WIDTH  = 640,
  parameter int HEIGHT = 360
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fhs_req_t  req_i,
  input  fhs_cmd_t  cmd_i,
  output fhs_stat_t stat_o,
  output logic      result_valid_o,
  output fhs_rsp_t  result_o
);

  // Cells past the 18-bit index range can never be addressed
  localparam int CELLS     = WIDTH * HEIGHT;
  localparam int MEM_DEPTH = (CELLS < (2 ** CellW)) ? CELLS : (2 ** CellW);
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam logic [CellW:0] WIDTH_X = (CellW + 1)'(WIDTH);
  localparam logic [31:0]    DEPTH_X = 32'(MEM_DEPTH);
  localparam logic [AW-1:0]  LAST_A  = AW'(MEM_DEPTH - 1);

  fhs_req_t         req_q;
  logic [AW-1:0]    clr_addr_q;
  logic [HeatW-1:0] mem [MEM_DEPTH];
  logic [HeatW-1:0] rd_data_q;
  logic             valid_q;
  fhs_rsp_t         rsp_q, rsp_d;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [HeatW-1:0] mem_wdata;

  logic             in_range;
  logic             top_row;
  logic [1:0]       choice;
  logic [CellW:0]   sum;
  logic [CellW:0]   sum_clamped;
  logic [CellW-1:0] dst;
  logic [HeatW-1:0] heat_dec;
  logic [HeatW-1:0] heat_res;

  // Hold the request while it is worked on
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
  end

  // Advance the clear sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_en && (clr_addr_q != LAST_A)) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  assign stat_o.clr_last = (clr_addr_q == LAST_A);

  // Decode the request
  assign in_range = ({{(32 - CellW){1'b0}}, req_q.cell_index} < DEPTH_X);
  assign top_row  = ({1'b0, req_q.cell_index} < WIDTH_X);
  assign choice   = (req_q.rand_choice == CHOICE_THREE) ? CHOICE_TWO : req_q.rand_choice;

  // Spread target one row up; clamp below the first row to cell zero
  assign sum         = {1'b0, req_q.cell_index} + (CellW + 1)'(1)
                       - {{(CellW - 1){1'b0}}, choice};
  assign sum_clamped = (sum < WIDTH_X) ? WIDTH_X : sum;
  assign dst         = CellW'(sum_clamped - WIDTH_X);

  // Cool the source heat by the low bit of the choice, floored at zero
  assign heat_dec = (rd_data_q >= {{(HeatW - 1){1'b0}}, choice[0]})
                    ? rd_data_q - {{(HeatW - 1){1'b0}}, choice[0]} : '0;

  // Select the write port and the result
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_q;
    mem_wdata = '0;
    heat_res  = '0;
    rsp_d.target_index = req_q.cell_index;
    rsp_d.heat_out     = '0;
    rsp_d.colour       = '0;
    rsp_d.rejected     = 1'b1;
    if (cmd_i.clr_en) begin
      mem_we = 1'b1;
    end else if (in_range) begin
      case (req_q.op)
        OP_SPREAD: begin
          if (!top_row) begin
            heat_res           = sat_heat(heat_dec);
            mem_we             = cmd_i.exec;
            mem_waddr          = dst[AW-1:0];
            mem_wdata          = heat_res;
            rsp_d.target_index = dst;
            rsp_d.rejected     = 1'b0;
          end
        end
        OP_WRITE: begin
          heat_res       = sat_heat(req_q.heat_in);
          mem_we         = cmd_i.exec;
          mem_waddr      = req_q.cell_index[AW-1:0];
          mem_wdata      = heat_res;
          rsp_d.rejected = 1'b0;
        end
        default: begin
          heat_res       = sat_heat(rd_data_q);
          rsp_d.rejected = 1'b0;
        end
      endcase
      if (!rsp_d.rejected) begin
        rsp_d.heat_out = heat_res;
        rsp_d.colour   = palette(heat_res);
      end
    end
  end

  // Heat store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[req_q.cell_index[AW-1:0]];
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  // Result strobe, one cycle per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.exec;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = rsp_q;

endmodule

// ----- rtl/core/fire_heat_spread.sv -----
// Fire heat spread block: a WIDTH x HEIGHT store of heat values 0..35 with spread,
// write and read operations. After reset, busy stays high while the store is swept
// to zero, one cell per cycle, WIDTH*HEIGHT cells (capped at 2**18). Each operation
// then goes from the start transfer to the result strobe through these steps:
// capture the request, the registered read of the heat store (one write port, one
// read port), then compute, write back and register the result. The strobe is high
// for exactly one cycle and cannot be stalled; a new start is taken in that same
// cycle, so operations never overlap. Depends on fhs_pkg, fhs_ctrl and fhs_dp.
`timescale 1ns / 1ps

module fire_heat_spread
  import fhs_pkg::*;
#(
  parameter int WIDTH  = 640,
  parameter int HEIGHT = 360
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  fhs_req_t req_i,
  output logic     result_valid_o,
  output fhs_rsp_t result_o
);

  fhs_cmd_t  cmd;
  fhs_stat_t stat;

  fhs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  fhs_dp #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ----- rtl/core/fhs_checker.sv -----
// Port-level checker of the fire heat spread block, bound to the top level.
// Depends on fhs_pkg and fire_heat_spread.
`timescale 1ns / 1ps

module fhs_checker
  import fhs_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     result_valid_o,
  input fhs_rsp_t result_o
);

  // An accepted transfer blocks further starts
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy low right after a start transfer");

  // Every accepted transfer yields its result strobe after the read and execute states
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 result_valid_o)
    else $error("result strobe missing three cycles after start");

  // The strobe marks a single cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  // A rejected operation reports no heat and no colour
  a_reject_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.rejected)
      |-> (result_o.heat_out == '0) && (result_o.colour == '0))
    else $error("rejected result carries heat or colour");

  // Heat never exceeds the hottest level
  a_heat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.heat_out <= HEAT_MAX))
    else $error("heat out of range");

endmodule

bind fire_heat_spread fhs_checker u_fhs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
